FILE: hdl/bdjr_pkg.sv
// ----------------------------------------------------------------------------
// bdjr_pkg
// Shared types and constants for the button debounce / joystick repeat block.
// ----------------------------------------------------------------------------
`default_nettype none

package bdjr_pkg;

	// full scale of one joystick axis
	localparam logic [11:0] AXIS_MAX = 12'd4095;

	// direction codes
	localparam logic [2:0] DIR_NONE  = 3'd0;
	localparam logic [2:0] DIR_LEFT  = 3'd1;
	localparam logic [2:0] DIR_RIGHT = 3'd2;
	localparam logic [2:0] DIR_UP    = 3'd3;
	localparam logic [2:0] DIR_DOWN  = 3'd4;

	// register index decoded from paddr[3:2]
	localparam logic [1:0] REG_BUTTON_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_SWITCH_DEBOUNCE = 2'd1;
	localparam logic [1:0] REG_DIR_THRESHOLD   = 2'd2;
	localparam logic [1:0] REG_REPEAT          = 2'd3;

	// register reset values
	localparam logic [15:0] BUTTON_DEBOUNCE_RST = 16'd50;
	localparam logic [15:0] SWITCH_DEBOUNCE_RST = 16'd50;
	localparam logic [11:0] DIR_THRESHOLD_RST   = 12'd1500;
	localparam logic [15:0] REPEAT_RST          = 16'd180;

	// configuration register contents
	typedef struct packed {
		logic [15:0] button_hold_ms;
		logic [15:0] switch_debounce_ms;
		logic [11:0] direction_threshold;
		logic [15:0] repeat_ms;
	} cfg_t;

	// per-switch debounce status for one item
	typedef struct packed {
		logic fell;
		logic rose;
		logic down;
	} deb_t;

endpackage

`default_nettype wire

FILE: hdl/bdjr_cfg_regs.sv
// ----------------------------------------------------------------------------
// bdjr_cfg_regs
// APB register file holding debounce times, direction threshold and repeat.
// ----------------------------------------------------------------------------
`default_nettype none

module bdjr_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [3:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic      [31:0]   prdata,
	output logic               pready,
	output bdjr_pkg::cfg_t     cfg
);

	bdjr_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [1:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.button_hold_ms      <= bdjr_pkg::BUTTON_DEBOUNCE_RST;
			cfg_q.switch_debounce_ms  <= bdjr_pkg::SWITCH_DEBOUNCE_RST;
			cfg_q.direction_threshold <= bdjr_pkg::DIR_THRESHOLD_RST;
			cfg_q.repeat_ms           <= bdjr_pkg::REPEAT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				bdjr_pkg::REG_BUTTON_DEBOUNCE: cfg_q.button_hold_ms      <= pwdata[15:0];
				bdjr_pkg::REG_SWITCH_DEBOUNCE: cfg_q.switch_debounce_ms  <= pwdata[15:0];
				bdjr_pkg::REG_DIR_THRESHOLD:   cfg_q.direction_threshold <= pwdata[11:0];
				bdjr_pkg::REG_REPEAT:          cfg_q.repeat_ms           <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			bdjr_pkg::REG_BUTTON_DEBOUNCE: prdata = {16'd0, cfg_q.button_hold_ms};
			bdjr_pkg::REG_SWITCH_DEBOUNCE: prdata = {16'd0, cfg_q.switch_debounce_ms};
			bdjr_pkg::REG_DIR_THRESHOLD:   prdata = {20'd0, cfg_q.direction_threshold};
			bdjr_pkg::REG_REPEAT:          prdata = {16'd0, cfg_q.repeat_ms};
			default:                       prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/bdjr_debounce.sv
// ----------------------------------------------------------------------------
// bdjr_debounce
// Debounce one active-low switch against a millisecond time stamp.
// ----------------------------------------------------------------------------
`default_nettype none

module bdjr_debounce (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        advance,
	input  wire logic        level,
	input  wire logic [31:0] now_ms,
	input  wire logic [15:0] hold_ms,
	output bdjr_pkg::deb_t   evt
);

	logic        last_raw_q;
	logic        stable_q;
	logic [31:0] stamp_q;
	logic [31:0] stamp_new;
	logic [31:0] elapsed;
	logic        settle;

	// a raw change restarts the timer
	assign stamp_new = (level != last_raw_q) ? now_ms : stamp_q;
	assign elapsed   = now_ms - stamp_new;
	assign settle    = (elapsed > {16'd0, hold_ms}) && (stable_q != level);

	assign evt.fell = settle & ~level;
	assign evt.rose = settle & level;
	assign evt.down = settle ? ~level : ~stable_q;

	// state update when the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q <= 1'b1;
			stable_q   <= 1'b1;
			stamp_q    <= 32'd0;
		end else if (advance) begin
			last_raw_q <= level;
			stamp_q    <= stamp_new;
			if (settle) begin
				stable_q <= level;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/bdjr_direction.sv
// ----------------------------------------------------------------------------
// bdjr_direction
// Joystick direction decode with fire-on-change and timed auto-repeat.
// ----------------------------------------------------------------------------
`default_nettype none

module bdjr_direction (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        advance,
	input  wire logic [31:0] now_ms,
	input  wire logic [11:0] x_sample,
	input  wire logic [11:0] y_sample,
	input  wire logic [11:0] threshold,
	input  wire logic [15:0] repeat_ms,
	output logic      [2:0]  fired
);

	logic [2:0]  held_q;
	logic [31:0] move_q;
	logic [11:0] far_end;
	logic [2:0]  dir;
	logic [31:0] since_move;
	logic        fire;

	assign far_end = bdjr_pkg::AXIS_MAX - threshold;

	// priority decode: left, right, up, down
	always_comb begin
		if (x_sample < threshold) begin
			dir = bdjr_pkg::DIR_LEFT;
		end else if (x_sample > far_end) begin
			dir = bdjr_pkg::DIR_RIGHT;
		end else if (y_sample < threshold) begin
			dir = bdjr_pkg::DIR_UP;
		end else if (y_sample > far_end) begin
			dir = bdjr_pkg::DIR_DOWN;
		end else begin
			dir = bdjr_pkg::DIR_NONE;
		end
	end

	// fire on a new direction or once the repeat period has run out
	assign since_move = now_ms - move_q;
	assign fire  = (dir != bdjr_pkg::DIR_NONE)
		&& ((dir != held_q) || (since_move >= {16'd0, repeat_ms}));
	assign fired = fire ? dir : bdjr_pkg::DIR_NONE;

	// held direction and last move time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= bdjr_pkg::DIR_NONE;
			move_q <= 32'd0;
		end else if (advance) begin
			if (dir == bdjr_pkg::DIR_NONE) begin
				held_q <= bdjr_pkg::DIR_NONE;
			end else if (fire) begin
				held_q <= dir;
				move_q <= now_ms;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/button_debounce_joystick_repeat.sv
// ----------------------------------------------------------------------------
// button_debounce_joystick_repeat
// Debounces two switches and turns joystick samples into repeating moves.
// ----------------------------------------------------------------------------
// Each accepted sampling pass gives exactly one result: the pass lands in an
// input register, the debounce and direction logic run on it and update their
// state as it moves into the result register. One pass can be taken every
// cycle; the rate is set only by the downstream side, since out_stall reaches
// in_stall through one gate when both registers are full. No clearing pass
// after reset. Registers sit at byte addresses 0x0 (button debounce ms), 0x4
// (switch debounce ms), 0x8 (direction threshold) and 0xC (repeat period ms);
// the user must write them only while idle; the block does not enforce this.
`default_nettype none

module button_debounce_joystick_repeat (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// sampling passes
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] now_ms,
	input  wire logic        button_level,
	input  wire logic        switch_level,
	input  wire logic [11:0] x_sample,
	input  wire logic [11:0] y_sample,
	// results
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             button_pressed,
	output logic             button_released,
	output logic             button_down,
	output logic             switch_pressed,
	output logic             switch_released,
	output logic             switch_down,
	output logic      [2:0]  direction_event,
	output logic      [11:0] x_value,
	output logic      [11:0] y_value
);

	bdjr_pkg::cfg_t cfg;
	bdjr_pkg::deb_t btn_evt;
	bdjr_pkg::deb_t sw_evt;
	logic [2:0]     fired;

	logic           valid_s1;
	logic [31:0]    now_ms_s1;
	logic           button_level_s1;
	logic           switch_level_s1;
	logic [11:0]    x_sample_s1;
	logic [11:0]    y_sample_s1;

	logic           valid_s2;
	bdjr_pkg::deb_t btn_evt_s2;
	bdjr_pkg::deb_t sw_evt_s2;
	logic [2:0]     dir_s2;
	logic [11:0]    x_value_s2;
	logic [11:0]    y_value_s2;

	logic           advance;

	// pipeline control
	assign advance  = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~advance;

	bdjr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			now_ms_s1       <= now_ms;
			button_level_s1 <= button_level;
			switch_level_s1 <= switch_level;
			x_sample_s1     <= x_sample;
			y_sample_s1     <= y_sample;
		end
	end

	bdjr_debounce u_btn_deb (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.level   (button_level_s1),
		.now_ms  (now_ms_s1),
		.hold_ms (cfg.button_hold_ms),
		.evt     (btn_evt)
	);

	bdjr_debounce u_sw_deb (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.level   (switch_level_s1),
		.now_ms  (now_ms_s1),
		.hold_ms (cfg.switch_debounce_ms),
		.evt     (sw_evt)
	);

	bdjr_direction u_dir (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.now_ms    (now_ms_s1),
		.x_sample  (x_sample_s1),
		.y_sample  (y_sample_s1),
		.threshold (cfg.direction_threshold),
		.repeat_ms (cfg.repeat_ms),
		.fired     (fired)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			btn_evt_s2 <= btn_evt;
			sw_evt_s2  <= sw_evt;
			dir_s2     <= fired;
			x_value_s2 <= x_sample_s1;
			y_value_s2 <= y_sample_s1;
		end
	end

	assign out_valid       = valid_s2;
	assign button_pressed  = btn_evt_s2.fell;
	assign button_released = btn_evt_s2.rose;
	assign button_down     = btn_evt_s2.down;
	assign switch_pressed  = sw_evt_s2.fell;
	assign switch_released = sw_evt_s2.rose;
	assign switch_down     = sw_evt_s2.down;
	assign direction_event = dir_s2;
	assign x_value         = x_value_s2;
	assign y_value         = y_value_s2;

`ifndef SYNTH
	// an item leaving the input register shows up as a result next cycle
	a_adv_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("advanced item did not reach the result register");

	// no item is taken while the input register holds one that cannot move
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> (!valid_s1 || advance))
		else $error("input register overwritten");

	// a button press pulse leaves the button down, a switch release leaves the switch up
	a_btn_press_down: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && button_pressed) |-> (button_down && !button_released))
		else $error("button press pulse inconsistent with level");

	a_sw_release_up: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && switch_released) |-> (!switch_down && !switch_pressed))
		else $error("switch release pulse inconsistent with level");

	// a fired direction is always a real direction code
	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (direction_event <= bdjr_pkg::DIR_DOWN))
		else $error("direction code out of range");
`endif

endmodule

`default_nettype wire
